// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define MRRL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define MRRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mrrl_pkg.sv =====
// Package with the codes, widths and reset values of the ring log block.
package mrrl_pkg;

    localparam int SLOTS_DEF      = 256;
    localparam int SLOT_WORDS_DEF = 8;
    localparam int READERS_DEF    = 8;

    localparam int CMD_W   = 3;
    localparam int DATA_W  = 64;
    localparam int IDX_W   = 31;
    localparam int CFG_W   = 31;
    localparam int CFGA_W  = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;
    localparam int MOD_STEPS = 31;

    localparam logic [IDX_W-1:0] TOP_INDEX = 31'h7FFF_FFFF;

    localparam logic [8:0]       ENTRIES_RST  = 9'd256;
    localparam logic [6:0]       CAPACITY_RST = 7'd64;
    localparam logic [IDX_W-1:0] WRAP_RST     = 31'd2147483392;

    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RD_IDX = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RD_REF = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RD_NEW = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RD_CUR = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CFGA_W-1:0] CFG_ENTRIES  = 2'd0;
    localparam logic [CFGA_W-1:0] CFG_CAPACITY = 2'd1;
    localparam logic [CFGA_W-1:0] CFG_WRAP     = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_META,
        S_LEN,
        S_RD,
        S_LOAD,
        S_WAIT
    } t_state;

endpackage

// ===== rtl/multi_reader_ring_log_unit.sv =====
// Ring log unit: an overwriting ring of entries addressed by sequence number.
// Every command is taken one at a time. The last word of a write burst, a clear
// or a query is taken and its single result beat is shown in the next; earlier
// write words give no beat. A read first reduces the sequence number minus one
// modulo the slot count in use with a bit-serial remainder unit (the MOD state),
// then reads the slot header in the META and LEN states and streams its payload
// words out of the synchronous payload memory, each word passing the RD, LOAD and
// WAIT states. A read that finds the ring empty or the index out of range answers
// in one beat without using the memories. The next command is taken once the last
// beat of the current one has been taken.
module multi_reader_ring_log_unit #(
    parameter int SLOTS      = mrrl_pkg::SLOTS_DEF,
    parameter int SLOT_WORDS = mrrl_pkg::SLOT_WORDS_DEF,
    parameter int READERS    = mrrl_pkg::READERS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mrrl_pkg::CFGA_W-1:0]   i_cfg_idx,
    input  logic [mrrl_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mrrl_pkg::CMD_W-1:0]    i_command,
    input  logic [mrrl_pkg::DATA_W-1:0]   i_data_word,
    input  logic                          i_word_last,
    input  logic [31:0]                   i_byte_length,
    input  logic [15:0]                   i_entry_type,
    input  logic [31:0]                   i_entry_user,
    input  logic [31:0]                   i_seq_index,
    input  logic signed [31:0]            i_refer_index,
    input  logic [2:0]                    i_reader_id,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mrrl_pkg::STAT_W-1:0]   o_status,
    output logic [mrrl_pkg::DATA_W-1:0]   o_payload_word,
    output logic                          o_run_last,
    output logic [mrrl_pkg::COUNT_W-1:0]  o_byte_count,
    output logic [15:0]                   o_type_out,
    output logic [31:0]                   o_user_out,
    output logic signed [31:0]            o_next_seq,
    output logic [mrrl_pkg::IDX_W-1:0]    o_oldest_seq,
    output logic [mrrl_pkg::IDX_W-1:0]    o_newest_seq,
    output logic [mrrl_pkg::IDX_W-1:0]    o_empty_index,
    output logic [mrrl_pkg::IDX_W-1:0]    o_old_total
);
    import mrrl_pkg::*;

    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int USED_W    = $clog2(SLOTS + 1);
    localparam int REM_W     = USED_W + 1;
    localparam int WORD_W    = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
    localparam int POS_W     = $clog2(SLOT_WORDS + 1);
    localparam int LEN_W     = $clog2(SLOT_WORDS * 8 + 1);
    localparam int RD_W      = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int MEM_DEPTH = SLOTS * (2 ** WORD_W);
    localparam int META_W    = LEN_W + 48;
    localparam int CNT_W     = $clog2(MOD_STEPS);

    // Configuration registers
    logic [8:0]       r_entries;
    logic [6:0]       r_capacity;
    logic [IDX_W-1:0] r_wrap;

    // Control state
    t_state               r_state, n_state;
    logic [SLOT_W-1:0]    r_wslot;
    logic [IDX_W-1:0]     r_seq;
    logic [POS_W-1:0]     r_pos;
    logic [31:0]          r_cursor [READERS];

    // Read job
    logic [IDX_W-1:0]     r_div;
    logic [REM_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_cnt;
    logic [31:0]          r_buflen;
    logic [31:0]          r_next_ok;
    logic [LEN_W-1:0]     r_copy;
    logic [WORD_W-1:0]    r_k;
    logic [WORD_W-1:0]    r_klast;
    logic [15:0]          r_rtype;
    logic [31:0]          r_ruser;

    // Output register
    logic                 r_out_valid;
    logic [STAT_W-1:0]    r_status;
    logic [DATA_W-1:0]    r_payload;
    logic                 r_out_last;
    logic [LEN_W-1:0]     r_count;
    logic [15:0]          r_type;
    logic [31:0]          r_user;
    logic [31:0]          r_next;
    logic [IDX_W-1:0]     r_old;

    // Memories
    logic [DATA_W-1:0]    r_pay_mem [MEM_DEPTH];
    logic [META_W-1:0]    r_meta_mem [SLOTS];
    logic [DATA_W-1:0]    r_pay_rd;
    logic [META_W-1:0]    r_meta_rd;

    logic                 accept;
    logic                 pay_re;
    logic                 meta_re;
    logic [USED_W-1:0]    used;
    logic [IDX_W-1:0]     first_idx, last_idx, empty_idx;

    // Slot count in use and the index window
    always_comb begin
        if (r_entries == 9'd0) begin
            used = USED_W'(1);
        end else if (32'(r_entries) > SLOTS) begin
            used = USED_W'(SLOTS);
        end else begin
            used = USED_W'(r_entries);
        end
        first_idx = (r_seq > IDX_W'(used)) ? r_seq - IDX_W'(used) + IDX_W'(1) : IDX_W'(1);
        last_idx  = (r_seq == '0) ? IDX_W'(1) : r_seq;
        if (r_seq == '0) begin
            empty_idx = IDX_W'(1);
        end else if (r_seq == TOP_INDEX) begin
            empty_idx = TOP_INDEX;
        end else begin
            empty_idx = r_seq + IDX_W'(1);
        end
    end

    // Write path
    logic [SLOT_W-1:0] wslot, wslot_next;
    logic [LEN_W-1:0]  cap, wcopy;
    logic [31:0]       seq_inc;

    always_comb begin
        wslot = (USED_W'(r_wslot) < used) ? r_wslot : '0;
        wslot_next = (USED_W'(wslot) + USED_W'(1) >= used) ? '0 : wslot + SLOT_W'(1);
        if (32'(r_capacity) < SLOT_WORDS * 8) begin
            cap = LEN_W'(r_capacity);
        end else begin
            cap = LEN_W'(SLOT_WORDS * 8);
        end
        wcopy = (i_byte_length <= 32'(cap)) ? LEN_W'(i_byte_length) : cap;
        seq_inc = {1'b0, r_seq} + 32'd1;
    end

    // Read setup, decided in the accept cycle
    logic              is_read;
    logic              rd_ok;
    logic [IDX_W-1:0]  rd_idx;
    logic [STAT_W-1:0] fail_status;
    logic [31:0]       fail_next;
    logic [31:0]       ok_next;
    logic [RD_W-1:0]   rid;
    logic              rid_bad;
    logic [31:0]       cur, cur_new;
    logic [IDX_W-1:0]  ref_idx;

    always_comb begin
        rid     = RD_W'(i_reader_id);
        rid_bad = (32'(i_reader_id) >= READERS);
        cur     = r_cursor[rid];
        if (cur[31] || (cur[IDX_W-1:0] < first_idx)) begin
            cur = {1'b0, first_idx};
        end
        ref_idx = (i_refer_index < $signed({1'b0, first_idx})) ?
                  first_idx : i_refer_index[IDX_W-1:0];

        is_read     = 1'b0;
        rd_ok       = 1'b0;
        rd_idx      = last_idx;
        fail_status = ST_EMPTY;
        fail_next   = '0;
        ok_next     = '0;
        cur_new     = cur;
        unique case (i_command)
            CMD_RD_IDX: begin
                is_read = 1'b1;
                rd_idx  = i_seq_index[IDX_W-1:0];
                if (r_seq == '0) begin
                    fail_status = ST_EMPTY;
                end else if ((i_seq_index < {1'b0, first_idx}) ||
                             (i_seq_index > {1'b0, last_idx})) begin
                    fail_status = ST_RANGE;
                end else begin
                    rd_ok = 1'b1;
                end
            end
            CMD_RD_REF: begin
                is_read   = 1'b1;
                fail_next = i_refer_index;
                rd_idx    = ref_idx;
                ok_next   = (ref_idx == TOP_INDEX) ? {1'b0, TOP_INDEX} :
                            {1'b0, ref_idx} + 32'd1;
                if (i_refer_index > $signed({1'b0, last_idx})) begin
                    fail_status = ST_RANGE;
                end else if (r_seq == '0) begin
                    fail_status = ST_EMPTY;
                end else begin
                    rd_ok = 1'b1;
                end
            end
            CMD_RD_NEW: begin
                is_read = 1'b1;
                rd_ok   = (r_seq != '0);
            end
            CMD_RD_CUR: begin
                is_read = 1'b1;
                rd_idx  = cur[IDX_W-1:0];
                if (rid_bad) begin
                    fail_status = ST_RANGE;
                end else if (r_seq == '0) begin
                    fail_status = ST_EMPTY;
                end else if (cur > {1'b0, last_idx}) begin
                    fail_status = ST_RANGE;
                end else begin
                    rd_ok = 1'b1;
                    cur_new = cur + 32'd1;
                    if (cur_new > {1'b0, r_wrap}) begin
                        cur_new = {1'b0, empty_idx};
                    end
                end
            end
            default: begin
                is_read = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_WRITE) begin
                        n_state = i_word_last ? S_WAIT : S_IDLE;
                    end else if (is_read && rd_ok) begin
                        n_state = S_MOD;
                    end else begin
                        n_state = S_WAIT;
                    end
                end
            end
            S_MOD: begin
                if (r_cnt == CNT_W'(MOD_STEPS - 1)) begin
                    n_state = S_META;
                end
            end
            S_META: n_state = S_LEN;
            S_LEN:  n_state = S_RD;
            S_RD:   n_state = S_LOAD;
            S_LOAD: n_state = S_WAIT;
            S_WAIT: begin
                if (r_out_valid && i_ready) begin
                    n_state = r_out_last ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_ready = (r_state == S_IDLE) && !r_out_valid;
        meta_re = (r_state == S_META);
        pay_re  = (r_state == S_RD);
    end

    assign accept = i_valid && o_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries  <= ENTRIES_RST;
            r_capacity <= CAPACITY_RST;
            r_wrap     <= WRAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENTRIES:  r_entries  <= i_cfg_data[8:0];
                CFG_CAPACITY: r_capacity <= i_cfg_data[6:0];
                CFG_WRAP:     r_wrap     <= i_cfg_data;
                default:      r_entries  <= r_entries;
            endcase
        end
    end

    // Control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wslot     <= '0;
            r_seq       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < READERS; i++) begin
                r_cursor[i] <= 32'd1;
            end
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_LOAD) begin
                r_out_valid <= 1'b1;
            end
            if (accept) begin
                if (i_command == CMD_WRITE) begin
                    if (i_word_last) begin
                        r_pos       <= '0;
                        r_wslot     <= wslot_next;
                        r_out_valid <= 1'b1;
                        if (seq_inc > {1'b0, r_wrap}) begin
                            r_seq <= '0;
                            for (int i = 0; i < READERS; i++) begin
                                r_cursor[i] <= 32'd1;
                            end
                        end else begin
                            r_seq <= seq_inc[IDX_W-1:0];
                        end
                    end else if (32'(r_pos) < SLOT_WORDS) begin
                        r_pos <= r_pos + POS_W'(1);
                    end
                end else begin
                    r_pos <= '0;
                    if (!(is_read && rd_ok)) begin
                        r_out_valid <= 1'b1;
                    end
                    if (i_command == CMD_CLEAR) begin
                        r_seq   <= '0;
                        r_wslot <= '0;
                        for (int i = 0; i < READERS; i++) begin
                            r_cursor[i] <= 32'd1;
                        end
                    end
                    if ((i_command == CMD_RD_CUR) && !rid_bad) begin
                        r_cursor[rid] <= cur_new;
                    end
                end
            end
        end
    end

    // Datapath: remainder unit, header latch, output beat
    logic [REM_W-1:0]  rem_try;
    logic [LEN_W-1:0]  meta_len, rcopy, base, left;
    logic [LEN_W:0]    words_sum;
    logic [POS_W-1:0]  words;
    logic [DATA_W-1:0] masked;

    always_comb begin
        rem_try  = {r_rem[USED_W-1:0], r_div[IDX_W-1]};
        meta_len = r_meta_rd[META_W-1 -: LEN_W];
        rcopy    = (r_buflen < 32'(meta_len)) ? LEN_W'(r_buflen) : meta_len;
        words_sum = {1'b0, rcopy} + (LEN_W + 1)'(7);
        words    = POS_W'(words_sum >> 3);
        if (words == '0) begin
            words = POS_W'(1);
        end
        base = LEN_W'({r_k, 3'b000});
        left = (r_copy > base) ? r_copy - base : '0;
        if (left == '0) begin
            masked = '0;
        end else if (left >= LEN_W'(8)) begin
            masked = r_pay_rd;
        end else begin
            masked = r_pay_rd & ~({DATA_W{1'b1}} << {left[2:0], 3'b000});
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buflen   <= i_byte_length;
            r_next_ok  <= (i_command == CMD_RD_REF) ? ok_next : '0;
            r_div      <= rd_idx - IDX_W'(1);
            r_rem      <= '0;
            r_cnt      <= '0;
            r_k        <= '0;
            r_payload  <= '0;
            r_out_last <= 1'b1;
            r_type     <= '0;
            r_user     <= '0;
            r_count    <= (i_command == CMD_WRITE) ? wcopy : '0;
            r_old      <= (i_command == CMD_CLEAR) ? r_seq : '0;
            if (is_read && !rd_ok) begin
                r_status <= fail_status;
                r_next   <= fail_next;
            end else begin
                r_status <= ST_OK;
                r_next   <= '0;
            end
        end
        if (r_state == S_MOD) begin
            r_div <= r_div << 1;
            r_cnt <= r_cnt + CNT_W'(1);
            if (rem_try >= {1'b0, used}) begin
                r_rem <= rem_try - {1'b0, used};
            end else begin
                r_rem <= rem_try;
            end
        end
        if (r_state == S_LEN) begin
            r_copy  <= rcopy;
            r_klast <= WORD_W'(words - POS_W'(1));
            r_rtype <= r_meta_rd[47:32];
            r_ruser <= r_meta_rd[31:0];
        end
        if (r_state == S_LOAD) begin
            r_status   <= ST_OK;
            r_payload  <= masked;
            r_out_last <= (r_k == r_klast);
            r_count    <= r_copy;
            r_type     <= r_rtype;
            r_user     <= r_ruser;
            r_next     <= r_next_ok;
            r_old      <= '0;
        end
        if ((r_state == S_WAIT) && r_out_valid && i_ready && !r_out_last) begin
            r_k <= r_k + WORD_W'(1);
        end
    end

    // Payload memory: written by write beats, read one word per read step
    always_ff @(posedge i_clk) begin
        if (accept && (i_command == CMD_WRITE) && (32'(r_pos) < SLOT_WORDS)) begin
            r_pay_mem[{wslot, r_pos[WORD_W-1:0]}] <= i_data_word;
        end
        if (pay_re) begin
            r_pay_rd <= r_pay_mem[{r_rem[SLOT_W-1:0], r_k}];
        end
    end

    // Slot header memory: length, type and user tag
    always_ff @(posedge i_clk) begin
        if (accept && (i_command == CMD_WRITE) && i_word_last) begin
            r_meta_mem[wslot] <= {wcopy, i_entry_type, i_entry_user};
        end
        if (meta_re) begin
            r_meta_rd <= r_meta_mem[r_rem[SLOT_W-1:0]];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_payload_word = r_payload;
    assign o_run_last     = r_out_last;
    assign o_byte_count   = COUNT_W'(r_count);
    assign o_type_out     = r_type;
    assign o_user_out     = r_user;
    assign o_next_seq     = r_next;
    assign o_oldest_seq   = first_idx;
    assign o_newest_seq   = last_idx;
    assign o_empty_index  = empty_idx;
    assign o_old_total    = r_old;

endmodule

// ===== rtl/mrrl_chk.sv =====
// Port-level checker for the ring log unit and its bind statement.
`include "assert_macros.svh"

module mrrl_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [mrrl_pkg::STAT_W-1:0]   o_status,
    input logic [mrrl_pkg::DATA_W-1:0]   o_payload_word,
    input logic                          o_run_last,
    input logic [mrrl_pkg::COUNT_W-1:0]  o_byte_count,
    input logic [mrrl_pkg::IDX_W-1:0]    o_oldest_seq,
    input logic [mrrl_pkg::IDX_W-1:0]    o_newest_seq,
    input logic [mrrl_pkg::IDX_W-1:0]    o_empty_index
);
    import mrrl_pkg::*;

    // A stalled result beat keeps its payload.
    `MRRL_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_payload_word), "result beat dropped or changed while stalled")

    // A new command is never taken while a result beat is still waiting.
    `MRRL_ASSERT_NOW(a_one_at_a_time, i_valid && o_ready, !o_valid, "command taken while a result waits")

    // Failed reads answer with one empty beat.
    `MRRL_ASSERT_NOW(a_fail_beat, o_valid && (o_status != ST_OK), o_run_last && (o_payload_word == '0) && (o_byte_count == '0), "failed read beat is not a single empty beat")

    // The index window stays ordered.
    `MRRL_ASSERT_NOW(a_window, o_valid, (o_oldest_seq <= o_empty_index) && (o_newest_seq <= o_empty_index), "sequence window out of order")

endmodule

bind multi_reader_ring_log_unit mrrl_chk u_mrrl_chk (.*);

// ===== tb/sv/tb.sv =====
// Testbench for the ring log unit: queued stimulus, a predictor and a beat checker.
module tb;
    import mrrl_pkg::*;

    localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd6;
    localparam logic [CMD_W-1:0] CMD_ALT_QUERY = 3'd7;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [63:0]       data;
        logic              last;
        logic [31:0]       blen;
        logic [15:0]       etype;
        logic [31:0]       euser;
        logic [31:0]       sidx;
        logic signed [31:0] refi;
        logic [2:0]        rid;
    } t_cmd_item;

    typedef struct {
        logic [STAT_W-1:0]  status;
        logic [63:0]        payload;
        logic               last;
        logic [COUNT_W-1:0] count;
        logic [15:0]        typ;
        logic [31:0]        user;
        logic [31:0]        next;
        logic [IDX_W-1:0]   first;
        logic [IDX_W-1:0]   newest;
        logic [IDX_W-1:0]   empty;
        logic [IDX_W-1:0]   old;
    } t_log_beat;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFGA_W-1:0]    i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [CMD_W-1:0]     i_command = '0;
    logic [DATA_W-1:0]    i_data_word = '0;
    logic                 i_word_last = 1'b0;
    logic [31:0]          i_byte_length = '0;
    logic [15:0]          i_entry_type = '0;
    logic [31:0]          i_entry_user = '0;
    logic [31:0]          i_seq_index = '0;
    logic signed [31:0]   i_refer_index = '0;
    logic [2:0]           i_reader_id = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [STAT_W-1:0]    o_status;
    logic [DATA_W-1:0]    o_payload_word;
    logic                 o_run_last;
    logic [COUNT_W-1:0]   o_byte_count;
    logic [15:0]          o_type_out;
    logic [31:0]          o_user_out;
    logic signed [31:0]   o_next_seq;
    logic [IDX_W-1:0]     o_oldest_seq;
    logic [IDX_W-1:0]     o_newest_seq;
    logic [IDX_W-1:0]     o_empty_index;
    logic [IDX_W-1:0]     o_old_total;

    multi_reader_ring_log_unit uut (.*);

    // Predictor state.
    logic [63:0]      pr_store [0:2047];
    logic [6:0]       pr_len [0:255];
    logic [15:0]      pr_type [0:255];
    logic [31:0]      pr_user [0:255];
    int unsigned      pr_wslot;
    logic [IDX_W-1:0] pr_total;
    logic [31:0]      pr_cursor [0:7];
    int unsigned      pr_pos;
    logic [8:0]       cfg_entries;
    logic [6:0]       cfg_cap;
    logic [IDX_W-1:0] cfg_wrap;

    t_cmd_item pending_cmds [$];
    t_log_beat expected_beats [$];
    int errors = 0;
    bit in_fire = 0, out_fire = 0;
    bit hold_go = 0, hold_done = 0, quiet = 0;
    int hold_left = 0, rx_wait = 0, tx_gap = 0, stall_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        if (quiet) return 0;
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
    endfunction

    function automatic int unsigned slots_live();
        if (cfg_entries == 0) return 1;
        if (cfg_entries > 256) return 256;
        return cfg_entries;
    endfunction

    function automatic longint oldest_seq();
        longint n;
        n = slots_live();
        return (pr_total > n) ? pr_total - n + 1 : 1;
    endfunction

    function automatic longint newest_seq();
        return (pr_total == 0) ? 1 : pr_total;
    endfunction

    function automatic longint next_seq();
        if (pr_total == 0) return 1;
        if (pr_total >= TOP_INDEX) return TOP_INDEX;
        return pr_total + 1;
    endfunction

    task automatic add_beat(input logic [1:0] st, input logic [63:0] pay, input longint cnt,
                            input logic [15:0] typ, input logic [31:0] usr,
                            input logic [31:0] nxt, input logic [IDX_W-1:0] old,
                            input logic lst);
        t_log_beat b;
        b.status = st;
        b.payload = pay;
        b.last = lst;
        b.count = cnt[6:0];
        b.typ = typ;
        b.user = usr;
        b.next = nxt;
        b.first = oldest_seq();
        b.newest = newest_seq();
        b.empty = next_seq();
        b.old = old;
        expected_beats.push_back(b);
    endtask

    task automatic read_slot(input longint idx, input logic [31:0] blen,
                             input logic [31:0] nok, input logic [31:0] nfail, output bit ok);
        int unsigned slot;
        longint len, copy, words, rem;
        logic [63:0] w;
        ok = 0;
        if (pr_total == 0) begin
            add_beat(ST_EMPTY, 0, 0, 0, 0, nfail, 0, 1'b1);
            return;
        end
        if (idx < oldest_seq() || idx > newest_seq()) begin
            add_beat(ST_RANGE, 0, 0, 0, 0, nfail, 0, 1'b1);
            return;
        end
        slot = (idx - 1) % slots_live();
        len = pr_len[slot];
        if (len > 64) len = 64;
        copy = (longint'(blen) < len) ? longint'(blen) : len;
        words = (copy + 7) / 8;
        if (words == 0) words = 1;
        for (int k = 0; k < words; k++) begin
            w = pr_store[slot * 8 + k];
            rem = (copy > 8 * k) ? copy - 8 * k : 0;
            if (rem == 0) w = 0;
            else if (rem < 8) w &= (64'h1 << (8 * rem)) - 64'h1;
            add_beat(ST_OK, w, copy, pr_type[slot], pr_user[slot], nok, 0, k == words - 1);
        end
        ok = 1;
    endtask

    task automatic predict(input t_cmd_item it);
        int unsigned n, slot;
        longint cap, copy, refer, idx;
        logic [31:0] cur, nok;
        logic [IDX_W-1:0] old;
        bit ok;
        n = slots_live();
        if (it.cmd == CMD_WRITE) begin
            slot = (pr_wslot < n) ? pr_wslot : 0;
            if (pr_pos < 8) begin
                pr_store[slot * 8 + pr_pos] = it.data;
                pr_pos++;
            end
            if (!it.last) return;
            cap = (cfg_cap < 64) ? cfg_cap : 64;
            copy = (longint'(it.blen) <= cap) ? longint'(it.blen) : cap;
            pr_len[slot] = copy[6:0];
            pr_type[slot] = it.etype;
            pr_user[slot] = it.euser;
            pr_wslot = (slot + 1 >= n) ? 0 : slot + 1;
            // The total is compared one bit wider so that it never folds over.
            if (longint'(pr_total) + 1 > longint'(cfg_wrap)) begin
                pr_total = 0;
                for (int r = 0; r < 8; r++) pr_cursor[r] = 1;
            end else begin
                pr_total++;
            end
            pr_pos = 0;
            add_beat(ST_OK, 0, copy, 0, 0, 0, 0, 1'b1);
            return;
        end
        pr_pos = 0;
        case (it.cmd)
            CMD_RD_IDX: read_slot(longint'(it.sidx), it.blen, 0, 0, ok);
            CMD_RD_REF: begin
                refer = longint'(it.refi);
                if (refer > newest_seq()) begin
                    add_beat(ST_RANGE, 0, 0, 0, 0, it.refi, 0, 1'b1);
                end else begin
                    idx = (refer < oldest_seq()) ? oldest_seq() : refer;
                    nok = (idx >= TOP_INDEX) ? 32'(TOP_INDEX) : 32'(idx + 1);
                    read_slot(idx, it.blen, nok, it.refi, ok);
                end
            end
            CMD_RD_NEW: read_slot(newest_seq(), it.blen, 0, 0, ok);
            CMD_RD_CUR: begin
                cur = pr_cursor[it.rid];
                if (cur > 32'h7FFF_FFFF || cur < oldest_seq()) cur = oldest_seq();
                read_slot(longint'(cur), it.blen, 0, 0, ok);
                if (ok) begin
                    cur++;
                    if (cur > cfg_wrap) cur = next_seq();
                end
                pr_cursor[it.rid] = cur;
            end
            CMD_CLEAR: begin
                old = pr_total;
                pr_total = 0;
                pr_wslot = 0;
                for (int r = 0; r < 8; r++) pr_cursor[r] = 1;
                add_beat(ST_OK, 0, 0, 0, 0, 0, old, 1'b1);
            end
            default: add_beat(ST_OK, 0, 0, 0, 0, 0, 0, 1'b1);
        endcase
    endtask

    function automatic t_cmd_item rand_cmd(input logic [CMD_W-1:0] cmd);
        t_cmd_item it;
        it.cmd = cmd;
        it.data = {$urandom, $urandom};
        it.last = $urandom_range(0, 1);
        it.blen = $urandom;
        it.etype = $urandom;
        it.euser = $urandom;
        it.sidx = $urandom;
        it.refi = $urandom;
        it.rid = $urandom;
        return it;
    endfunction

    task automatic send(input t_cmd_item it);
        predict(it);
        pending_cmds.push_back(it);
    endtask

    // Words a burst must carry so that every word a later read returns was written.
    function automatic int words_needed(input logic [31:0] len);
        longint cap, copy;
        cap = (cfg_cap < 64) ? cfg_cap : 64;
        copy = (longint'(len) < cap) ? longint'(len) : cap;
        return (copy == 0) ? 1 : int'((copy + 7) / 8);
    endfunction

    task automatic write_burst(input logic [31:0] len, input int nwords);
        t_cmd_item it;
        for (int k = 0; k < nwords; k++) begin
            it = rand_cmd(CMD_WRITE);
            it.last = (k == nwords - 1);
            it.blen = len;
            send(it);
        end
    endtask

    task automatic send_read(input logic [CMD_W-1:0] cmd, input logic [31:0] sidx,
                             input logic [31:0] blen);
        t_cmd_item it;
        it = rand_cmd(cmd);
        it.sidx = sidx;
        it.refi = sidx;
        it.blen = blen;
        send(it);
    endtask

    task automatic run_random(input int count);
        t_cmd_item it;
        int sent, r, nw;
        logic [31:0] len, blen;
        longint pick;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            blen = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 72);
            pick = oldest_seq() - 2 + $urandom_range(0, int'(newest_seq() - oldest_seq()) + 4);
            if ($urandom_range(0, 9) == 0) pick = $urandom;
            if (r < 6) begin
                // A burst that is left open; the next command either continues or abandons it.
                nw = $urandom_range(1, 3);
                for (int k = 0; k < nw; k++) begin
                    it = rand_cmd(CMD_WRITE);
                    it.last = 1'b0;
                    send(it);
                end
                sent += nw;
            end else if (r < 45) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 72);
                nw = words_needed(len) + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
                write_burst(len, nw);
                sent += nw;
            end else begin
                if (r < 60) send_read(CMD_RD_IDX, 32'(pick), blen);
                else if (r < 72) send_read(CMD_RD_REF, 32'(pick), blen);
                else if (r < 80) send_read(CMD_RD_NEW, 0, blen);
                else if (r < 92) send_read(CMD_RD_CUR, 0, blen);
                else if (r < 95) send(rand_cmd(CMD_CLEAR));
                else send(rand_cmd($urandom_range(0, 1) ? CMD_QUERY : CMD_ALT_QUERY));
                sent++;
            end
        end
    endtask

    task automatic wait_idle();
        while (!(pending_cmds.size() == 0 && expected_beats.size() == 0 && !i_valid))
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFGA_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ENTRIES:  cfg_entries = val[8:0];
            CFG_CAPACITY: cfg_cap = val[6:0];
            default:      cfg_wrap = val;
        endcase
    endtask

    task automatic set_regs(input int ent, input int cap, input int wrap);
        write_reg(CFG_ENTRIES, CFG_W'(ent));
        write_reg(CFG_CAPACITY, CFG_W'(cap));
        write_reg(CFG_WRAP, CFG_W'(wrap));
    endtask

    task automatic directed();
        t_cmd_item it;
        send(rand_cmd(CMD_QUERY));
        send_read(CMD_RD_NEW, 0, 64);
        send_read(CMD_RD_IDX, 1, 64);
        send_read(CMD_RD_CUR, 0, 64);
        send_read(CMD_RD_REF, 1, 64);
        for (int k = 0; k < 8; k++) begin
            it = rand_cmd(CMD_WRITE);
            it.data = '1;
            it.last = (k == 7);
            it.blen = 64;
            it.etype = 16'hFFFF;
            it.euser = 32'hFFFF_FFFF;
            send(it);
        end
        it = rand_cmd(CMD_WRITE);
        it.data = '0;
        it.last = 1'b1;
        it.blen = 0;
        it.etype = 0;
        it.euser = 0;
        send(it);
        // Words past the slot size are dropped and the length is truncated.
        write_burst(100, 10);
        // An open burst abandoned by a read keeps its words in the slot.
        for (int k = 0; k < 2; k++) begin
            it = rand_cmd(CMD_WRITE);
            it.last = 1'b0;
            it.blen = 13;
            send(it);
        end
        send_read(CMD_RD_IDX, 1, 64);
        write_burst(13, 2);
        send_read(CMD_RD_IDX, 0, 64);
        send_read(CMD_RD_IDX, 32'hFFFF_FFFF, 64);
        send_read(CMD_RD_IDX, 1, 0);
        send_read(CMD_RD_IDX, 3, 5);
        send_read(CMD_RD_REF, 32'h8000_0000, 64);
        send_read(CMD_RD_REF, 32'h7FFF_FFFF, 64);
        send_read(CMD_RD_REF, 2, 32'hFFFF_FFFF);
        it = rand_cmd(CMD_RD_CUR);
        it.rid = 0;
        send(it);
        send(it);
        it.rid = 7;
        send(it);
        send(rand_cmd(CMD_ALT_QUERY));
        send(rand_cmd(CMD_CLEAR));
    endtask

    // Command driver.
    always @(negedge i_clk) begin
        if (i_valid && !in_fire) begin
        end else if (tx_gap > 0) begin
            i_valid <= 1'b0;
            tx_gap <= tx_gap - 1;
        end else if (i_rst_n && pending_cmds.size() > 0) begin
            t_cmd_item it;
            it = pending_cmds.pop_front();
            i_command <= it.cmd;
            i_data_word <= it.data;
            i_word_last <= it.last;
            i_byte_length <= it.blen;
            i_entry_type <= it.etype;
            i_entry_user <= it.euser;
            i_seq_index <= it.sidx;
            i_refer_index <= it.refi;
            i_reader_id <= it.rid;
            i_valid <= 1'b1;
            tx_gap <= draw_gap();
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Result receiver, including one long hold-off that backs the block up.
    always @(negedge i_clk) begin
        int w;
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            i_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (rx_wait > 0) begin
            i_ready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end else if (out_fire) begin
            w = draw_gap();
            i_ready <= (w == 0);
            rx_wait <= (w > 0) ? w - 1 : 0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic check_field(input string nm, input logic [63:0] e, input logic [63:0] a);
        if (e !== a) begin
            errors++;
            $display("%0t %s mismatch: expected %0h actual %0h", $time, nm, e, a);
        end
    endtask

    // Result monitor and stall watchdog.
    always @(posedge i_clk) begin
        t_log_beat eb;
        in_fire <= i_valid && o_ready;
        out_fire <= o_valid && i_ready;
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we || !i_rst_n) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_beats.size() == 0) begin
                errors++;
                $display("%0t unexpected beat: expected none actual status %0h payload %0h",
                         $time, o_status, o_payload_word);
            end else begin
                eb = expected_beats.pop_front();
                check_field("status", eb.status, o_status);
                check_field("payload_word", eb.payload, o_payload_word);
                check_field("run_last", eb.last, o_run_last);
                check_field("byte_count", eb.count, o_byte_count);
                check_field("type_out", eb.typ, o_type_out);
                check_field("user_out", eb.user, o_user_out);
                check_field("next_seq", eb.next, o_next_seq);
                check_field("oldest_seq", eb.first, o_oldest_seq);
                check_field("newest_seq", eb.newest, o_newest_seq);
                check_field("empty_index", eb.empty, o_empty_index);
                check_field("old_total", eb.old, o_old_total);
            end
        end
    end

    initial begin
        cfg_entries = ENTRIES_RST;
        cfg_cap = CAPACITY_RST;
        cfg_wrap = WRAP_RST;
        pr_wslot = 0;
        pr_total = 0;
        pr_pos = 0;
        for (int r = 0; r < 8; r++) pr_cursor[r] = 1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        set_regs(int'(ENTRIES_RST), int'(CAPACITY_RST), int'(WRAP_RST));
        directed();
        run_random(25);
        send(rand_cmd(CMD_CLEAR));
        wait_idle();
        // One slot and a wrap limit of one: every second commit restarts the total.
        set_regs(1, 0, 1);
        run_random(20);
        send(rand_cmd(CMD_CLEAR));
        wait_idle();
        set_regs(4, 20, 8);
        run_random(30);
        send(rand_cmd(CMD_CLEAR));
        wait_idle();
        set_regs(256, 64, 32'h7FFF_FFFF);
        hold_go = 1;
        run_random(30);
        send(rand_cmd(CMD_CLEAR));
        wait_idle();
        set_regs(7, 64, 21);
        quiet = 1;
        run_random(15);
        quiet = 0;
        run_random(15);
        wait_idle();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
